/* rtl/aes_pkg.sv */
package aes_pkg;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_W0   = 3'd1;
  localparam logic [2:0] CFG_KEY_W1   = 3'd2;
  localparam logic [2:0] CFG_KEY_W2   = 3'd3;
  localparam logic [2:0] CFG_KEY_W3   = 3'd4;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

/* rtl/aes_round.sv */
// One full cipher or inverse-cipher round on the 128-bit state (byte 0 in top bits).
module cipher_round import aes_pkg::*; (
  input  logic [127:0] state,
  input  logic [127:0] rkey,
  input  logic         dec,
  input  logic         last,
  output logic [127:0] result
);

  logic [7:0] b [16];
  logic [7:0] s [16];
  logic [7:0] m [16];
  logic [7:0] k [16];
  logic [7:0] x2, x4, x8, y0, y1, y2, y3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = state[127 - 8*i -: 8];
      k[i] = rkey[127 - 8*i -: 8];
    end
    // shift rows plus S-box
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          s[4*((c + r) % 4) + r] = INV_SBOX[b[4*c + r]];
        end else begin
          s[4*c + r] = SBOX[b[4*((c + r) % 4) + r]];
        end
      end
    end
    // decrypt: add key before mix; encrypt: after
    for (int i = 0; i < 16; i++) begin
      m[i] = dec ? (s[i] ^ k[i]) : s[i];
    end
    result = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        x2 = '0;
        x4 = '0;
        y0 = m[4*c + r];
        y1 = m[4*c + ((r + 1) % 4)];
        y2 = m[4*c + ((r + 2) % 4)];
        y3 = m[4*c + ((r + 3) % 4)];
        if (last) begin
          x8 = y0;
        end else if (!dec) begin
          x8 = xtime(y0) ^ xtime(y1) ^ y1 ^ y2 ^ y3;
        end else begin
          // 14,11,13,9
          x2 = xtime(y0);  x4 = xtime(x2); x8 = xtime(x4) ^ x4 ^ x2;
          x2 = xtime(y1);  x4 = xtime(x2); x8 = x8 ^ xtime(x4) ^ x2 ^ y1;
          x2 = xtime(y2);  x4 = xtime(x2); x8 = x8 ^ xtime(x4) ^ x4 ^ y2;
          x2 = xtime(y3);  x4 = xtime(x2); x8 = x8 ^ xtime(x4) ^ y3;
        end
        result[127 - 8*(4*c + r) -: 8] = dec ? x8 : (x8 ^ k[4*c + r]);
      end
    end
  end

endmodule

/* rtl/aes_block_encrypt_decrypt.sv */
// AES-128/192/256 block cipher. Write key_size and key words through the cfg port; the
// first request after a write to either rebuilds the 60-word round key store, one word a cycle
// (Nb*(Nr+1) words: 44, 52 or 60). The store is a single-read-port memory holding 32-bit
// words, so each 128-bit round key is gathered by four reads and applied once its fourth
// word is on the read port. A block needs Nr+1 round keys; the next request is taken only
// once the block has left DONE, and the rebuild comes first when the key changed.
// A finished result waits in an output register; the next request is accepted while it
// waits, and a later result holds in DONE until the earlier one is taken. Requests are
// held off in any cycle that offers a register write.
module aes_block_encrypt_decrypt import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  aes_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output aes_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [2:0] {IDLE, EXPAND, LOAD, RUN, DONE} state_t;

  state_t       st;
  logic [1:0]   key_size;
  logic [63:0]  kw0, kw1, kw2, kw3;
  logic         sched_ok;

  // round key store
  logic [31:0]  rk_mem [60];
  logic [31:0]  rk_rd;
  logic [5:0]   rd_addr, wr_addr;
  logic         wr_en;
  logic [31:0]  wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wr_addr] <= wr_data;
    rk_rd <= rk_mem[rd_addr];
  end

  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [5:0]   total;
  logic [2:0]   wback;
  assign nk    = (key_size == KS_128) ? 4'd4 : (key_size == KS_192) ? 4'd6 : 4'd8;
  assign nr    = nk + 4'd6;
  assign total = {nr, 2'b00} + 6'd4;
  assign wback = 3'(4'd8 - nk);

  // expansion: keep last 8 words in a window so no read is needed
  logic [31:0]  win [8];
  logic [5:0]   ei;
  logic [2:0]   emod;
  logic [7:0]   rc;
  logic [31:0]  t_rot, t_word, key_in;

  always_comb begin
    case (ei[2:0])
      3'd0: key_in = kw0[63:32];
      3'd1: key_in = kw0[31:0];
      3'd2: key_in = kw1[63:32];
      3'd3: key_in = kw1[31:0];
      3'd4: key_in = kw2[63:32];
      3'd5: key_in = kw2[31:0];
      3'd6: key_in = kw3[63:32];
      default: key_in = kw3[31:0];
    endcase
    t_rot = sub_word({win[7][23:0], win[7][31:24]}) ^ {rc, 24'd0};
    if (emod == 3'd0) begin
      t_word = win[wback] ^ t_rot;
    end else if (nk == 4'd8 && emod == 3'd4) begin
      t_word = win[0] ^ sub_word(win[7]);
    end else begin
      t_word = win[wback] ^ win[7];
    end
    wr_en   = (st == EXPAND);
    wr_addr = ei;
    wr_data = (ei < {2'b00, nk}) ? key_in : t_word;
  end

  // cipher datapath
  logic         dec;
  logic [127:0] blk, rkey, rkey_full, rnd_out;
  logic [3:0]   rnd;
  logic [1:0]   wsel;
  logic         rd_pend;
  logic         last;

  // full round key once the fourth word is on the read port
  assign rkey_full = {rkey[95:0], rk_rd};

  cipher_round u_round (
    .state  (blk),
    .rkey   (rkey_full),
    .dec    (dec),
    .last   (last),
    .result (rnd_out)
  );

  assign last = dec ? (rnd == 4'd0) : (rnd == nr);

  // round-key word address for current read: round rr, column wsel
  logic [3:0]   rr;
  always_comb begin
    rr = rnd;
    rd_addr = {rr, 2'b00} + {4'd0, wsel};
  end

  assign in_stall  = (st != IDLE) || cfg_valid;
  assign cfg_ready = (st == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= IDLE;
      key_size  <= KS_128;
      kw0       <= '0; kw1 <= '0; kw2 <= '0; kw3 <= '0;
      sched_ok  <= 1'b0;
      out_valid <= 1'b0;
      ei        <= '0;
      emod      <= '0;
      rc        <= 8'h01;
      wsel      <= '0;
      rd_pend   <= 1'b0;
      rnd       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_SIZE: begin
            key_size <= (cfg_data[1:0] == 2'd3) ? KS_256 : cfg_data[1:0];
            sched_ok <= 1'b0;
          end
          CFG_KEY_W0: begin kw0 <= cfg_data; sched_ok <= 1'b0; end
          CFG_KEY_W1: begin kw1 <= cfg_data; sched_ok <= 1'b0; end
          CFG_KEY_W2: begin kw2 <= cfg_data; sched_ok <= 1'b0; end
          CFG_KEY_W3: begin kw3 <= cfg_data; sched_ok <= 1'b0; end
          default: ;
        endcase
      end
      case (st)
        IDLE: begin
          if (in_valid && !in_stall) begin
            dec <= in_data.req_type;
            blk <= {in_data.block_hi, in_data.block_lo};
            if (sched_ok) begin
              st <= LOAD;
            end else begin
              st <= EXPAND;
              ei <= '0; emod <= '0; rc <= 8'h01;
            end
            rnd     <= in_data.req_type ? nr : 4'd0;
            wsel    <= '0;
            rd_pend <= 1'b0;
          end
        end
        EXPAND: begin
          for (int j = 0; j < 7; j++) win[j] <= win[j + 1];
          win[7] <= wr_data;
          // window indexing: win[7] holds w[i-1], win[8-nk] holds w[i-nk]
          if (ei >= {2'b00, nk} && emod == 3'd0) rc <= xtime(rc);
          ei   <= ei + 6'd1;
          emod <= (emod == nk[2:0] - 3'd1 || (nk == 4'd8 && emod == 3'd7)) ? 3'd0
                  : emod + 3'd1;
          if (ei == total - 6'd1) begin
            st       <= LOAD;
            sched_ok <= 1'b1;
          end
        end
        LOAD, RUN: begin
          // issue four reads, collect into rkey; then apply
          if (rd_pend) rkey <= rkey_full;
          if (rd_pend && wsel == 2'd0) begin
            // rkey completed this cycle with the final word
            if (st == LOAD) begin
              blk <= blk ^ rkey_full;
              st  <= RUN;
              rnd <= dec ? rnd - 4'd1 : rnd + 4'd1;
            end else begin
              blk <= rnd_out;
              if (last) begin
                st <= DONE;
              end else begin
                rnd <= dec ? rnd - 4'd1 : rnd + 4'd1;
              end
            end
            rd_pend <= 1'b0;
          end else begin
            rd_pend <= (wsel != 2'd0) || !rd_pend;
            wsel    <= wsel + 2'd1;
          end
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= blk;
            out_valid <= 1'b1;
            st        <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
      if (out_valid && !out_stall && st != DONE) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/aes_chk.sv */
module aes_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("accepted request did not block");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_ready && in_valid && !in_stall))
    else $error("request taken together with a register write");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

bind aes_block_encrypt_decrypt aes_chk u_chk (.*);
